[hdl/tlssh_pkg.sv]
// Shared types and constants for the TLS ServerHello parser.
// No dependencies; imported by tls_server_hello_parser_top.

package tlssh_pkg;

   localparam int RANDOM_BYTES   = 32;
   localparam int MAX_SESSION_ID = 32;

   localparam int RND_IDX_W = $clog2(RANDOM_BYTES);
   localparam int POS_W     = 16;
   localparam int SID_W     = 6;

   localparam logic [SID_W-1:0] SID_LEN_SAT = {SID_W{1'b1}};

   localparam logic [15:0] VERSION_TLS12 = 16'h0303;
   localparam logic [15:0] VERSION_SSL3  = 16'h0300;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_TRUNCATED = 2'd1;
   localparam status_type STATUS_SID_LONG  = 2'd2;
   localparam status_type STATUS_EXT_LEN   = 2'd3;

   typedef enum logic [11:0] {
      PH_VER_HI    = 12'b0000_0000_0001,
      PH_VER_LO    = 12'b0000_0000_0010,
      PH_RANDOM    = 12'b0000_0000_0100,
      PH_SID_LEN   = 12'b0000_0000_1000,
      PH_SID       = 12'b0000_0001_0000,
      PH_SUITE_HI  = 12'b0000_0010_0000,
      PH_SUITE_LO  = 12'b0000_0100_0000,
      PH_COMP      = 12'b0000_1000_0000,
      PH_EXTLEN_HI = 12'b0001_0000_0000,
      PH_EXTLEN_LO = 12'b0010_0000_0000,
      PH_EXT       = 12'b0100_0000_0000,
      PH_DRAIN     = 12'b1000_0000_0000
   } phase_type;

   // HelloRetryRequest marker: SHA-256 of "HelloRetryRequest"
   localparam logic [7:0] RETRY_MARKER [RANDOM_BYTES] = '{
      8'hCF, 8'h21, 8'hAD, 8'h74, 8'hE5, 8'h9A, 8'h61, 8'h11,
      8'hBE, 8'h1D, 8'h8C, 8'h02, 8'h1E, 8'h65, 8'hB8, 8'h91,
      8'hC2, 8'hA2, 8'h11, 8'h16, 8'h7A, 8'hBB, 8'h8C, 8'h5E,
      8'h07, 8'h9E, 8'h09, 8'hE2, 8'hC8, 8'hA8, 8'h33, 8'h9C
   };

endpackage

[hdl/tls_server_hello_parser_top.sv]
// TLS ServerHello body parser: byte-wide input, one result beat per message.
// Depends on tlssh_pkg.
//
// Usage:
//   req_ carries the message body one byte per beat; req_last_byte marks the
//   final byte. A beat is taken when req_valid is high and req_stall low.
//   rsp_ carries one result beat per message, issued for the last byte only:
//   status, version, retry flag, session id length, cipher suite, compression
//   and extensions length. A beat leaves when rsp_valid is high and rsp_stall
//   low.
//   The last byte taken is held in the input register and is parsed into the
//   result register as soon as the result register is free.
//   Throughput: one byte per cycle while req_stall is low, set by the single
//   parse step between the input register and the result register.
//   When the receiver stalls, the held result stays put; non-final bytes keep
//   flowing, and a final byte waits in the input register until the result
//   register frees, which back-pressures req_stall.
//   Reset (synchronous, active high) empties both registers and returns the
//   parser to the start of a message.

module tls_server_hello_parser_top
   import tlssh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_protocol_version,
   output logic        rsp_is_hello_retry,
   output logic [5:0]  rsp_session_id_length,
   output logic [15:0] rsp_cipher_suite,
   output logic [7:0]  rsp_compression_method,
   output logic [15:0] rsp_extensions_length,
   output logic        rsp_has_extensions
);

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;

   // parser state
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [15:0]        version_ff, version_in;
   logic               match_ff, match_in;
   logic [SID_W-1:0]   session_len_ff, session_len_in;
   logic [15:0]        suite_ff, suite_in;
   logic [7:0]         comp_ff, comp_in;
   logic [15:0]        ext_len_ff, ext_len_in;
   status_type         error_ff, error_in;

   // result register
   logic               rsp_valid_ff;
   status_type         status_ff, status_in;
   logic [15:0]        res_version_ff;
   logic               retry_ff, retry_in;
   logic [SID_W-1:0]   res_sid_len_ff;
   logic [15:0]        res_suite_ff;
   logic [7:0]         res_comp_ff;
   logic [15:0]        res_ext_len_ff;
   logic               has_ext_ff, has_ext_in;

   logic               out_free;
   logic               proc;
   logic               finish;
   logic               random_done;
   logic [POS_W-1:0]   pos_inc;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // a final byte needs room in the result register; others always proceed
   assign proc      = in_valid_ff && (!in_last_ff || out_free);
   assign finish    = proc && in_last_ff;
   assign req_stall = in_valid_ff && !proc;
   assign pos_inc   = position_ff + POS_W'(1);

   always_comb begin
      phase_in       = phase_ff;
      position_in    = position_ff;
      version_in     = version_ff;
      match_in       = match_ff;
      session_len_in = session_len_ff;
      suite_in       = suite_ff;
      comp_in        = comp_ff;
      ext_len_in     = ext_len_ff;
      error_in       = error_ff;
      case (phase_ff)
         PH_VER_HI: begin
            version_in = {in_data_ff, 8'h00};
            phase_in   = PH_VER_LO;
         end
         PH_VER_LO: begin
            version_in  = {version_ff[15:8], in_data_ff};
            position_in = '0;
            phase_in    = PH_RANDOM;
         end
         PH_RANDOM: begin
            if (in_data_ff != RETRY_MARKER[position_ff[RND_IDX_W-1:0]])
               match_in = 1'b0;
            position_in = pos_inc;
            if (pos_inc >= POS_W'(RANDOM_BYTES)) begin
               position_in = '0;
               phase_in    = PH_SID_LEN;
            end
         end
         PH_SID_LEN: begin
            session_len_in = (in_data_ff > 8'(SID_LEN_SAT)) ? SID_LEN_SAT
                                                            : in_data_ff[SID_W-1:0];
            if (in_data_ff > 8'(MAX_SESSION_ID)) begin
               if (error_ff == STATUS_OK)
                  error_in = STATUS_SID_LONG;
               phase_in = PH_DRAIN;
            end else begin
               position_in = '0;
               phase_in    = (in_data_ff == 8'h00) ? PH_SUITE_HI : PH_SID;
            end
         end
         PH_SID: begin
            position_in = pos_inc;
            if (pos_inc >= POS_W'(session_len_ff))
               phase_in = PH_SUITE_HI;
         end
         PH_SUITE_HI: begin
            suite_in = {in_data_ff, 8'h00};
            phase_in = PH_SUITE_LO;
         end
         PH_SUITE_LO: begin
            suite_in = {suite_ff[15:8], in_data_ff};
            phase_in = PH_COMP;
         end
         PH_COMP: begin
            comp_in  = in_data_ff;
            phase_in = PH_EXTLEN_HI;
         end
         PH_EXTLEN_HI: begin
            ext_len_in = {in_data_ff, 8'h00};
            phase_in   = PH_EXTLEN_LO;
         end
         PH_EXTLEN_LO: begin
            ext_len_in  = {ext_len_ff[15:8], in_data_ff};
            position_in = '0;
            phase_in    = PH_EXT;
         end
         PH_EXT: begin
            if (position_ff >= ext_len_ff) begin
               if (error_ff == STATUS_OK)
                  error_in = STATUS_EXT_LEN;
            end else begin
               position_in = pos_inc;
            end
         end
         PH_DRAIN: begin
            phase_in = PH_DRAIN;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // result taken from the state after this byte
   always_comb begin
      if (error_in != STATUS_OK)
         status_in = error_in;
      else if (phase_in == PH_EXT)
         status_in = (position_in == ext_len_in) ? STATUS_OK : STATUS_EXT_LEN;
      else if (phase_in == PH_EXTLEN_HI && version_in == VERSION_SSL3)
         status_in = STATUS_OK;
      else
         status_in = STATUS_TRUNCATED;
      random_done = !(phase_in == PH_VER_HI || phase_in == PH_VER_LO ||
                      phase_in == PH_RANDOM);
      retry_in    = (version_in == VERSION_TLS12) && random_done && match_in;
      has_ext_in  = (phase_in == PH_EXT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         phase_ff       <= PH_VER_HI;
         position_ff    <= '0;
         version_ff     <= '0;
         match_ff       <= 1'b1;
         session_len_ff <= '0;
         suite_ff       <= '0;
         comp_ff        <= '0;
         ext_len_ff     <= '0;
         error_ff       <= STATUS_OK;
      end else if (proc) begin
         phase_ff       <= phase_in;
         position_ff    <= position_in;
         version_ff     <= version_in;
         match_ff       <= match_in;
         session_len_ff <= session_len_in;
         suite_ff       <= suite_in;
         comp_ff        <= comp_in;
         ext_len_ff     <= ext_len_in;
         error_ff       <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff      <= status_in;
         res_version_ff <= version_in;
         retry_ff       <= retry_in;
         res_sid_len_ff <= session_len_in;
         res_suite_ff   <= suite_in;
         res_comp_ff    <= comp_in;
         res_ext_len_ff <= ext_len_in;
         has_ext_ff     <= has_ext_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_protocol_version   = res_version_ff;
   assign rsp_is_hello_retry     = retry_ff;
   assign rsp_session_id_length  = res_sid_len_ff;
   assign rsp_cipher_suite       = res_suite_ff;
   assign rsp_compression_method = res_comp_ff;
   assign rsp_extensions_length  = res_ext_len_ff;
   assign rsp_has_extensions     = has_ext_ff;

   // a new result beat only follows a final byte being parsed
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_last_ff))
      else $error("result beat without a final byte");

   // parser is back at the start of a message after a final byte
   a_restart: assert property (@(posedge clock) disable iff (reset)
      finish |=> (phase_ff == PH_VER_HI && error_ff == STATUS_OK && match_ff))
      else $error("parser not restarted after final byte");

   // error code is sticky until the message ends
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (error_ff != STATUS_OK && !finish) |=> (error_ff == $past(error_ff)))
      else $error("error code changed mid-message");

   // session id counter never runs past the declared length
   a_sid_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SID) |-> (position_ff < POS_W'(session_len_ff)))
      else $error("session id position out of range");

endmodule

[bench/hello_check_pkg.sv]
`timescale 1ns / 1ps
// Byte-level prediction of the ServerHello parser and the result scoreboard.
// Depends on tlssh_pkg for phases, status codes and the retry marker.

package hello_check_pkg;
   import tlssh_pkg::*;

   typedef struct packed {
      status_type       status;
      logic [15:0]      version;
      logic             retry;
      logic [SID_W-1:0] sid_len;
      logic [15:0]      suite;
      logic [7:0]       comp;
      logic [15:0]      ext_len;
      logic             has_ext;
   } hello_summary_type;

   class hello_scoreboard_type;
      phase_type        phase;
      logic [POS_W-1:0] position;
      logic [15:0]      version;
      logic             marker_ok;
      logic [SID_W-1:0] sid_len;
      logic [15:0]      suite;
      logic [7:0]       comp;
      logic [15:0]      ext_len;
      status_type       err;

      hello_summary_type pending_summaries[$];
      int                errors;
      int                checked;
      int                status_seen[4];
      int                retry_seen;

      function void clear_parse();
         phase     = PH_VER_HI;
         position  = '0;
         version   = '0;
         marker_ok = 1'b1;
         sid_len   = '0;
         suite     = '0;
         comp      = '0;
         ext_len   = '0;
         err       = STATUS_OK;
      endfunction

      function int pending();
         return pending_summaries.size();
      endfunction

      // Advance the parse by one accepted byte; a final byte yields a summary.
      function void parse_byte(logic [7:0] b, logic last);
         hello_summary_type s;
         logic              random_done;
         case (phase)
            PH_VER_HI: begin
               version = {b, 8'h00};
               phase   = PH_VER_LO;
            end
            PH_VER_LO: begin
               version[7:0] = b;
               position     = '0;
               phase        = PH_RANDOM;
            end
            PH_RANDOM: begin
               if (b != RETRY_MARKER[position[RND_IDX_W-1:0]])
                  marker_ok = 1'b0;
               position = position + POS_W'(1);
               if (position >= POS_W'(RANDOM_BYTES)) begin
                  position = '0;
                  phase    = PH_SID_LEN;
               end
            end
            PH_SID_LEN: begin
               sid_len = (b > 8'(SID_LEN_SAT)) ? SID_LEN_SAT : b[SID_W-1:0];
               if (b > 8'(MAX_SESSION_ID)) begin
                  if (err == STATUS_OK)
                     err = STATUS_SID_LONG;
                  phase = PH_DRAIN;
               end else begin
                  position = '0;
                  phase    = (b == 8'd0) ? PH_SUITE_HI : PH_SID;
               end
            end
            PH_SID: begin
               position = position + POS_W'(1);
               if (position >= POS_W'(sid_len))
                  phase = PH_SUITE_HI;
            end
            PH_SUITE_HI: begin
               suite = {b, 8'h00};
               phase = PH_SUITE_LO;
            end
            PH_SUITE_LO: begin
               suite[7:0] = b;
               phase      = PH_COMP;
            end
            PH_COMP: begin
               comp  = b;
               phase = PH_EXTLEN_HI;
            end
            PH_EXTLEN_HI: begin
               ext_len = {b, 8'h00};
               phase   = PH_EXTLEN_LO;
            end
            PH_EXTLEN_LO: begin
               ext_len[7:0] = b;
               position     = '0;
               phase        = PH_EXT;
            end
            PH_EXT: begin
               // bytes beyond the declared length spoil the message for good
               if (position >= ext_len) begin
                  if (err == STATUS_OK)
                     err = STATUS_EXT_LEN;
               end else begin
                  position = position + POS_W'(1);
               end
            end
            default: ;
         endcase
         if (!last)
            return;

         if (err != STATUS_OK)
            s.status = err;
         else if (phase == PH_EXT)
            s.status = (position == ext_len) ? STATUS_OK : STATUS_EXT_LEN;
         else if (phase == PH_EXTLEN_HI && version == VERSION_SSL3)
            s.status = STATUS_OK;
         else
            s.status = STATUS_TRUNCATED;

         random_done = !(phase == PH_VER_HI || phase == PH_VER_LO || phase == PH_RANDOM);
         s.version = version;
         s.retry   = (version == VERSION_TLS12) && random_done && marker_ok;
         s.sid_len = sid_len;
         s.suite   = suite;
         s.comp    = comp;
         s.ext_len = ext_len;
         s.has_ext = (phase == PH_EXT);
         pending_summaries.push_back(s);
         clear_parse();
      endfunction

      function void cmp_field(string name, logic [15:0] want, logic [15:0] got_v);
         if (want !== got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got_v);
         end
      endfunction

      function void check_result(hello_summary_type got);
         hello_summary_type want;
         if (pending_summaries.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing outstanding, got %p", $time, got);
            return;
         end
         want = pending_summaries.pop_front();
         checked++;
         cmp_field("status", 16'(want.status), 16'(got.status));
         cmp_field("protocol_version", want.version, got.version);
         cmp_field("is_hello_retry", 16'(want.retry), 16'(got.retry));
         cmp_field("session_id_length", 16'(want.sid_len), 16'(got.sid_len));
         cmp_field("cipher_suite", want.suite, got.suite);
         cmp_field("compression_method", 16'(want.comp), 16'(got.comp));
         cmp_field("extensions_length", want.ext_len, got.ext_len);
         cmp_field("has_extensions", 16'(want.has_ext), 16'(got.has_ext));
         status_seen[want.status]++;
         if (want.retry)
            retry_seen++;
      endfunction
   endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for tls_server_hello_parser_top: builds whole and broken
// ServerHello bodies, drives them byte-wise, checks every result beat.
// Depends on tlssh_pkg, hello_check_pkg and the parser RTL.

module tb_top;
   import tlssh_pkg::*;
   import hello_check_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 8;

   typedef enum int {RND_RANDOM, RND_MARKER, RND_FLIPPED} rnd_kind_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_protocol_version;
   logic        rsp_is_hello_retry;
   logic [5:0]  rsp_session_id_length;
   logic [15:0] rsp_cipher_suite;
   logic [7:0]  rsp_compression_method;
   logic [15:0] rsp_extensions_length;
   logic        rsp_has_extensions;

   hello_scoreboard_type sb;
   hello_summary_type    seen;
   logic [7:0]           msg_q[$];
   int                   burst_left;
   int                   bytes_sent;
   int                   msgs_sent;
   int                   quiet_cycles;
   bit                   hold_request;

   tls_server_hello_parser_top DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_data_byte          (req_data_byte),
      .req_last_byte          (req_last_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_protocol_version   (rsp_protocol_version),
      .rsp_is_hello_retry     (rsp_is_hello_retry),
      .rsp_session_id_length  (rsp_session_id_length),
      .rsp_cipher_suite       (rsp_cipher_suite),
      .rsp_compression_method (rsp_compression_method),
      .rsp_extensions_length  (rsp_extensions_length),
      .rsp_has_extensions     (rsp_has_extensions)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // Message body into msg_q; stops after the length byte if the id is too long,
   // or after the compression byte when there is no extensions part.
   task automatic build_hello(input logic [15:0] ver, input rnd_kind_type rk, input int sid,
                              input logic [15:0] suite, input logic [7:0] comp,
                              input bit with_ext, input int decl, input int cnt);
      int         i;
      int         flip_at;
      logic [7:0] flip_val;
      msg_q.delete();
      msg_q.push_back(ver[15:8]);
      msg_q.push_back(ver[7:0]);
      flip_at  = $urandom_range(0, RANDOM_BYTES - 1);
      flip_val = 8'($urandom_range(1, 255));
      for (i = 0; i < RANDOM_BYTES; i++) begin
         case (rk)
            RND_MARKER:  msg_q.push_back(RETRY_MARKER[i]);
            RND_FLIPPED: msg_q.push_back(i == flip_at ? RETRY_MARKER[i] ^ flip_val
                                                      : RETRY_MARKER[i]);
            default:     msg_q.push_back(rand_byte());
         endcase
      end
      msg_q.push_back(sid[7:0]);
      if (sid > MAX_SESSION_ID)
         return;
      repeat (sid) msg_q.push_back(rand_byte());
      msg_q.push_back(suite[15:8]);
      msg_q.push_back(suite[7:0]);
      msg_q.push_back(comp);
      if (!with_ext)
         return;
      msg_q.push_back(decl[15:8]);
      msg_q.push_back(decl[7:0]);
      repeat (cnt) msg_q.push_back(rand_byte());
   endtask

   task automatic add_noise(input int n);
      repeat (n) msg_q.push_back(rand_byte());
   endtask

   task automatic trim_msg(input int n);
      while (msg_q.size() > n)
         void'(msg_q.pop_back());
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.parse_byte(b, last);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_msg();
      int i;
      for (i = 0; i < msg_q.size(); i++)
         send_byte(msg_q[i], i == msg_q.size() - 1);
      msgs_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      burst_left = 0;
   endtask

   // Receiver: stretches of differing stall density, plus one long hold on request.
   initial begin
      int hold_left;
      int stretch_left;
      int stall_pct;
      bit hold_taken;
      hold_left    = 0;
      stretch_left = 0;
      stall_pct    = 0;
      hold_taken   = 1'b0;
      rsp_stall   <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(20, 200);
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  2:       stall_pct = 50;
                  default: stall_pct = 80;
               endcase
            end
            stretch_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Result checking and the watchdog on handshake activity.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid && !rsp_stall) begin
            seen.status  = rsp_status;
            seen.version = rsp_protocol_version;
            seen.retry   = rsp_is_hello_retry;
            seen.sid_len = rsp_session_id_length;
            seen.suite   = rsp_cipher_suite;
            seen.comp    = rsp_compression_method;
            seen.ext_len = rsp_extensions_length;
            seen.has_ext = rsp_has_extensions;
            sb.check_result(seen);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end else begin
         quiet_cycles = 0;
      end
   end

   initial begin
      logic [15:0]  ver;
      rnd_kind_type rk;
      int           kind;
      int           sid;
      int           decl;
      int           cnt;
      bit           with_ext;
      int           rnd_msgs;

      sb = new();
      sb.clear_parse();
      burst_left    = 0;
      bytes_sent    = 0;
      msgs_sent     = 0;
      hold_request  = 1'b0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= 8'h00;
      req_last_byte <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: lone byte, retry marker hit / miss / cut short
      msg_q.delete();
      msg_q.push_back(8'h03);
      send_msg();
      build_hello(VERSION_TLS12, RND_MARKER, 0, 16'h1301, 8'h00, 1'b1, 0, 0);
      send_msg();
      build_hello(VERSION_TLS12, RND_FLIPPED, 32, 16'hFFFF, 8'hFF, 1'b1, 3, 3);
      send_msg();
      build_hello(VERSION_TLS12, RND_MARKER, 0, 16'h1302, 8'h00, 1'b1, 0, 0);
      trim_msg(20);
      send_msg();
      // SSL3 without extensions, then with one stray byte; other version cut there
      build_hello(VERSION_SSL3, RND_RANDOM, 16, 16'h000A, 8'h00, 1'b0, 0, 0);
      send_msg();
      build_hello(VERSION_SSL3, RND_RANDOM, 0, 16'h0005, 8'h01, 1'b0, 0, 0);
      add_noise(1);
      send_msg();
      build_hello(16'h0301, RND_RANDOM, 5, 16'h002F, 8'h00, 1'b0, 0, 0);
      send_msg();
      // over-long session ids, incl. one that saturates the length field
      build_hello(VERSION_TLS12, RND_MARKER, 33, 16'h0, 8'h0, 1'b1, 0, 0);
      add_noise(10);
      send_msg();
      build_hello(16'hFFFF, RND_RANDOM, 255, 16'h0, 8'h0, 1'b1, 0, 0);
      add_noise(3);
      send_msg();
      // extension count too high, too low, huge declared length
      build_hello(VERSION_TLS12, RND_MARKER, 8, 16'h1303, 8'h00, 1'b1, 4, 6);
      send_msg();
      build_hello(VERSION_TLS12, RND_RANDOM, 1, 16'hC02F, 8'h00, 1'b1, 10, 3);
      send_msg();
      build_hello(16'hFFFF, RND_RANDOM, 32, 16'hFFFF, 8'hFF, 1'b1, 65535, 2);
      send_msg();
      build_hello(16'h0000, RND_RANDOM, 0, 16'h0000, 8'h00, 1'b1, 0, 0);
      send_msg();
      build_hello(VERSION_TLS12, RND_RANDOM, 4, 16'h1301, 8'h00, 1'b1, 256, 256);
      send_msg();
      // ends right after the high extensions length byte, and inside the session id
      build_hello(VERSION_TLS12, RND_RANDOM, 2, 16'h1301, 8'h00, 1'b1, 0, 0);
      trim_msg(msg_q.size() - 1);
      send_msg();
      build_hello(VERSION_TLS12, RND_MARKER, 20, 16'h1301, 8'h00, 1'b1, 0, 0);
      trim_msg(45);
      send_msg();
      wait_drained();

      rnd_msgs = 0;
      while (bytes_sent < 2000 || rnd_msgs < 14) begin
         if (rnd_msgs == 4)
            hold_request = 1'b1;
         if (rnd_msgs == 12)
            wait_drained();
         kind = $urandom_range(0, 99);
         case ($urandom_range(0, 4))
            0, 1:    ver = VERSION_TLS12;
            2:       ver = VERSION_SSL3;
            default: ver = 16'($urandom_range(0, 16'hFFFF));
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: rk = RND_MARKER;
            5, 6:          rk = RND_FLIPPED;
            default:       rk = RND_RANDOM;
         endcase
         if ($urandom_range(0, 3) == 0)
            sid = $urandom_range(0, 1) ? MAX_SESSION_ID : 0;
         else
            sid = $urandom_range(0, MAX_SESSION_ID);
         decl     = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(0, 24);
         with_ext = (ver == VERSION_SSL3) ? 1'($urandom_range(0, 1)) : 1'b1;
         if (rnd_msgs >= 4 && rnd_msgs < 10) begin
            // short messages while the receiver holds off, to back up the block
            msg_q.delete();
            add_noise($urandom_range(1, 3));
         end else if (kind < 60) begin
            build_hello(ver, rk, sid, {rand_byte(), rand_byte()}, rand_byte(),
                        with_ext, decl, decl);
         end else if (kind < 75) begin
            build_hello(ver, rk, sid, 16'($urandom_range(0, 16'hFFFF)), rand_byte(),
                        with_ext, decl, decl);
            trim_msg($urandom_range(1, msg_q.size() - 1));
         end else if (kind < 85) begin
            case ($urandom_range(0, 2))
               0: begin
                  decl = $urandom_range(0, 16'hFFFF);
                  cnt  = $urandom_range(0, 30);
               end
               1: cnt = decl + $urandom_range(1, 5);
               default: begin
                  decl = $urandom_range(1, 30);
                  cnt  = $urandom_range(0, decl - 1);
               end
            endcase
            build_hello(ver, rk, sid, 16'($urandom_range(0, 16'hFFFF)), rand_byte(),
                        1'b1, decl, cnt);
         end else if (kind < 95) begin
            build_hello(ver, rk, $urandom_range(MAX_SESSION_ID + 1, 255), 16'h0, 8'h0,
                        1'b1, 0, 0);
            add_noise($urandom_range(0, 20));
         end else begin
            msg_q.delete();
            add_noise($urandom_range(1, 60));
         end
         send_msg();
         rnd_msgs++;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d messages in %0d bytes; %0d results checked, %0d with retry marker.",
               msgs_sent, bytes_sent, sb.checked, sb.retry_seen);
      $display("Status mix: ok %0d, truncated %0d, session id too long %0d, ext mismatch %0d.",
               sb.status_seen[STATUS_OK], sb.status_seen[STATUS_TRUNCATED],
               sb.status_seen[STATUS_SID_LONG], sb.status_seen[STATUS_EXT_LEN]);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
